### rtl/lpte_pkg.sv
// package: types, codes and helpers of the long-press timed enable core
`timescale 1ns / 1ps

package lpte_pkg;

  // width of the saturating time counters
  localparam int TIME_BITS = 32;
  // fixed widths of the register and field values
  localparam int CFG_BITS = 32;
  localparam int SHORT_BITS = 16;
  localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [TIME_BITS-1:0] time_t;

  // press phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_LONG    = 2'd2;

  // item modes
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_ENABLE  = 2'd1;
  localparam logic [1:0] MODE_DISABLE = 2'd2;

  // shutdown kinds
  localparam logic [1:0] SHUT_NONE    = 2'd0;
  localparam logic [1:0] SHUT_TIMEOUT = 2'd1;
  localparam logic [1:0] SHUT_SOFT    = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REBOOT_PRESS   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_WINDOW = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE       = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COOLDOWN       = 3'd4;

  typedef struct packed {
    logic [1:0]          mode;
    logic                button_level;
    logic                radio_ready;
    logic [CFG_BITS-1:0] request_duration;
    logic                feedback_request;
  } item_t;

  typedef struct packed {
    logic                pressed_stable;
    logic                window_open;
    logic                feedback_on;
    logic [CFG_BITS-1:0] remaining_ms;
    logic                start_pulse;
    logic                enable_failed;
    logic [1:0]          shutdown_kind;
    logic                reboot_request;
  } result_t;

  typedef struct packed {
    logic [CFG_BITS-1:0]   long_press_ms;
    logic [CFG_BITS-1:0]   reboot_press_ms;
    logic [CFG_BITS-1:0]   default_window_ms;
    logic [SHORT_BITS-1:0] debounce_ms;
    logic [SHORT_BITS-1:0] cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            press_phase;
    time_t                 press_elapsed;
    logic                  last_raw;
    logic                  stable_level;
    time_t                 quiet_elapsed;
    logic [SHORT_BITS-1:0] cooldown_left;
    logic                  window_active;
    logic                  feedback_flag;
    time_t                 window_length;
    time_t                 window_elapsed;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    long_press_ms:     32'd3000,
    reboot_press_ms:   32'd10000,
    default_window_ms: 32'd300000,
    debounce_ms:       16'd50,
    cooldown_ms:       16'd500
  };

  localparam state_t STATE_RESET = '{
    press_phase:    PH_IDLE,
    press_elapsed:  '0,
    last_raw:       1'b1,
    stable_level:   1'b1,
    quiet_elapsed:  '0,
    cooldown_left:  '0,
    window_active:  1'b0,
    feedback_flag:  1'b0,
    window_length:  '0,
    window_elapsed: '0
  };

  // counter step that sticks at all ones
  function automatic time_t sat_inc(time_t v);
    return (v == '1) ? v : v + time_t'(1);
  endfunction

  // time counter against a 32-bit limit, both zero extended
  function automatic logic at_least(time_t t, logic [CFG_BITS-1:0] lim);
    return CMP_BITS'(t) >= CMP_BITS'(lim);
  endfunction

  function automatic time_t to_time(logic [CFG_BITS-1:0] v);
    return TIME_BITS'(v);
  endfunction

endpackage

### rtl/lpte_item_if.sv
// interfaces: input item channel and result channel
`timescale 1ns / 1ps

interface lpte_item_if;
  logic                 valid;
  logic                 ready;
  lpte_pkg::item_t      payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lpte_result_if;
  logic                 valid;
  logic                 ready;
  lpte_pkg::result_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/long_press_timed_enable_core.sv
// top level: debounced long-press detector with a timed enable window
// path: each item passes the input register, then the result register
// throughput: one item per cycle; a waiting result lets one more item into an empty input
// register, then the input stalls until the result is taken
// reset: synchronous, active high; the configuration registers return to their power-on values,
// both stages empty, press state idle and the window closed
`timescale 1ns / 1ps

module long_press_timed_enable_core (
  input  logic                                 clk,
  input  logic                                 rst,
  lpte_item_if.sink                            item,
  lpte_result_if.source                        result,
  input  logic                                 cfg_we,
  input  logic [lpte_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lpte_pkg::CFG_BITS-1:0]        cfg_data
);
  import lpte_pkg::*;

  // configuration registers
  cfg_t    cfg;

  // architectural state of the detector and the window
  state_t  st;
  state_t  st_next;

  // input stage
  logic    s1_valid;
  item_t   s1_item;

  // result stage
  logic    res_valid;
  result_t res;
  result_t res_next;

  // the input stage moves on whenever the result register is free or being drained
  logic    advance;

  assign advance     = s1_valid && (!res_valid || result.ready);
  assign item.ready  = !s1_valid || advance;

  assign result.valid   = res_valid;
  assign result.payload = res;

  // all per-tick work sits between the two stages
  lpte_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (s1_item),
    .st_next (st_next),
    .res     (res_next)
  );

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS:     cfg.long_press_ms     <= cfg_data;
        CFG_REBOOT_PRESS:   cfg.reboot_press_ms   <= cfg_data;
        CFG_DEFAULT_WINDOW: cfg.default_window_ms <= cfg_data;
        CFG_DEBOUNCE:       cfg.debounce_ms       <= cfg_data[SHORT_BITS-1:0];
        CFG_COOLDOWN:       cfg.cooldown_ms       <= cfg_data[SHORT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item <= item.payload;
    end
  end

  // state commits only when the tick's result is captured
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

### rtl/lpte_step.sv
// one tick of the press detector and the enable window, combinational
`timescale 1ns / 1ps

module lpte_step (
  input  lpte_pkg::state_t  st,
  input  lpte_pkg::cfg_t    cfg,
  input  lpte_pkg::item_t   item,
  output lpte_pkg::state_t  st_next,
  output lpte_pkg::result_t res
);
  import lpte_pkg::*;

  state_t     s;
  logic       ev_start;
  logic       ev_fail;
  logic [1:0] ev_shutdown;
  logic       ev_reboot;
  logic       pressed;
  time_t      prior;

  always_comb begin
    s           = st;
    ev_start    = 1'b0;
    ev_fail     = 1'b0;
    ev_shutdown = SHUT_NONE;
    ev_reboot   = 1'b0;
    pressed     = 1'b0;
    prior       = '0;

    // time advances
    s.quiet_elapsed = sat_inc(st.quiet_elapsed);
    if (st.press_phase != PH_IDLE) begin
      s.press_elapsed = sat_inc(st.press_elapsed);
    end
    if (st.window_active) begin
      s.window_elapsed = sat_inc(st.window_elapsed);
    end
    if (st.cooldown_left != '0) begin
      s.cooldown_left = st.cooldown_left - 1'b1;
    end

    // software command
    case (item.mode)
      MODE_ENABLE: begin
        s.window_length  = (item.request_duration != '0) ? to_time(item.request_duration)
                                                          : to_time(cfg.default_window_ms);
        s.window_elapsed = '0;
        s.window_active  = item.radio_ready;
        s.feedback_flag  = item.radio_ready & item.feedback_request;
        ev_start         = item.radio_ready;
        ev_fail          = ~item.radio_ready;
      end
      MODE_DISABLE: begin
        if (s.window_active) begin
          s.window_active = 1'b0;
          s.feedback_flag = 1'b0;
          ev_shutdown     = SHUT_SOFT;
        end
      end
      default: ;
    endcase

    // debounce, frozen during cooldown
    if (s.cooldown_left == '0) begin
      prior = s.quiet_elapsed;
      if (item.button_level != s.last_raw) begin
        s.quiet_elapsed = '0;
      end
      if (CMP_BITS'(prior) > CMP_BITS'(cfg.debounce_ms)) begin
        s.stable_level = item.button_level;
      end
      s.last_raw = item.button_level;
      pressed    = ~s.stable_level;
    end

    // press phase
    unique case (s.press_phase)
      PH_IDLE: begin
        if (pressed) begin
          s.press_phase   = PH_PRESSED;
          s.press_elapsed = '0;
        end
      end
      PH_PRESSED: begin
        if (!pressed) begin
          s.press_phase   = PH_IDLE;
          s.cooldown_left = cfg.cooldown_ms;
        end else begin
          if (at_least(s.press_elapsed, cfg.reboot_press_ms)) begin
            ev_reboot = 1'b1;
          end
          if (at_least(s.press_elapsed, cfg.long_press_ms)) begin
            s.press_phase    = PH_LONG;
            s.window_length  = to_time(cfg.default_window_ms);
            s.window_elapsed = '0;
            s.window_active  = item.radio_ready;
            s.feedback_flag  = item.radio_ready;
            ev_start         = ev_start | item.radio_ready;
            ev_fail          = ev_fail | ~item.radio_ready;
          end
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          s.press_phase = PH_IDLE;
        end else if (at_least(s.press_elapsed, cfg.reboot_press_ms)) begin
          ev_reboot = 1'b1;
        end
      end
      default: begin
        s.press_phase = PH_IDLE;
      end
    endcase

    // timeout wins over a soft stop in the same tick
    if (s.window_active && (s.window_elapsed >= s.window_length)) begin
      s.window_active = 1'b0;
      s.feedback_flag = 1'b0;
      ev_shutdown     = SHUT_TIMEOUT;
    end

    st_next            = s;
    res.pressed_stable = (s.cooldown_left == '0) && !s.stable_level;
    res.window_open    = s.window_active;
    res.feedback_on    = s.window_active & s.feedback_flag;
    res.remaining_ms   = s.window_active ? CFG_BITS'(s.window_length - s.window_elapsed) : '0;
    res.start_pulse    = ev_start;
    res.enable_failed  = ev_fail;
    res.shutdown_kind  = ev_shutdown;
    res.reboot_request = ev_reboot;
  end

endmodule

### rtl/lpte_checker.sv
// port checker for the long-press timed enable core, bound to the top level
`timescale 1ns / 1ps

module lpte_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input lpte_pkg::result_t result_payload
);
  import lpte_pkg::*;

  // nothing comes out in the cycle after reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // with no result pending the block always takes an item
  assert property (@(posedge clk) disable iff (rst) !result_valid |-> item_ready)
    else $error("input stalled while result side empty");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_payload))
    else $error("stalled result changed");

  // a closed window shows no time left and no feedback
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_payload.window_open |->
      (result_payload.remaining_ms == '0) && !result_payload.feedback_on)
    else $error("closed window reports time or feedback");

  // start and refusal come from the same radio state, never together
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result_payload.start_pulse && result_payload.enable_failed))
    else $error("start and failure in one tick");

endmodule

bind long_press_timed_enable_core lpte_checker u_lpte_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_payload (result.payload)
);

### bench/long_press_timed_enable_core_test.sv
// testbench: long-press timed enable core against a cycle-free predictor of each tick
`timescale 1ns / 1ps

module long_press_timed_enable_core_test;
  import lpte_pkg::*;

  // mode 3 has no meaning of its own and must act as a plain tick
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // watchdog, many times the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 228;
  // cycles to let pass after the last result (input and result register)
  localparam int SETTLE_CYCLES = 4;

  // ---------------------------------------------------------------------------
  // scoreboard: mirror of the press and window state plus the queue of
  // expected results, one per accepted tick
  // ---------------------------------------------------------------------------
  class press_window_scoreboard;
    logic [CFG_BITS-1:0]   long_hold;
    logic [CFG_BITS-1:0]   reboot_hold;
    logic [CFG_BITS-1:0]   dflt_len;
    logic [SHORT_BITS-1:0] quiet_need;
    logic [SHORT_BITS-1:0] cool_len;

    logic [1:0]            phase;
    time_t                 hold_t;
    logic                  prev_raw;
    logic                  level;
    time_t                 quiet_t;
    logic [SHORT_BITS-1:0] cool_t;
    logic                  win_on;
    logic                  fb_on;
    time_t                 win_len;
    time_t                 win_t;

    logic                  started;
    logic                  failed;
    logic [1:0]            shut_kind;
    logic                  reboot_hit;

    result_t               expected_ticks[$];
    int                    errors;
    int                    shown;

    function new();
      long_hold   = 32'd3000;
      reboot_hold = 32'd10000;
      dflt_len    = 32'd300000;
      quiet_need  = 16'd50;
      cool_len    = 16'd500;
      phase       = PH_IDLE;
      hold_t      = '0;
      prev_raw    = 1'b1;
      level       = 1'b1;
      quiet_t     = '0;
      cool_t      = '0;
      win_on      = 1'b0;
      fb_on       = 1'b0;
      win_len     = '0;
      win_t       = '0;
      errors      = 0;
      shown       = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
        CFG_LONG_PRESS:     long_hold = val;
        CFG_REBOOT_PRESS:   reboot_hold = val;
        CFG_DEFAULT_WINDOW: dflt_len = val;
        CFG_DEBOUNCE:       quiet_need = val[SHORT_BITS-1:0];
        CFG_COOLDOWN:       cool_len = val[SHORT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void open_win(time_t len, logic fb, logic rdy);
      win_len = (len != '0) ? len : time_t'(dflt_len);
      win_t = '0;
      if (rdy) begin
        win_on = 1'b1;
        fb_on = fb;
        started = 1'b1;
      end else begin
        win_on = 1'b0;
        fb_on = 1'b0;
        failed = 1'b1;
      end
    endfunction

    function void close_win(logic [1:0] kind);
      if (!win_on) return;
      win_on = 1'b0;
      fb_on = 1'b0;
      shut_kind = kind;
    endfunction

    // leading-edge debounce, frozen while the cooldown runs
    function logic sample_button(logic raw);
      time_t prior;
      if (cool_t != '0) return 1'b0;
      prior = quiet_t;
      if (raw != prev_raw) quiet_t = '0;
      if (64'(prior) > 64'(quiet_need)) level = raw;
      prev_raw = raw;
      return level == 1'b0;
    endfunction

    function result_t predict_tick(item_t it);
      result_t r;
      logic    held;
      time_t   left;
      started = 1'b0;
      failed = 1'b0;
      shut_kind = SHUT_NONE;
      reboot_hit = 1'b0;
      left = '0;

      if (quiet_t != '1) quiet_t = quiet_t + 1'b1;
      if (phase != PH_IDLE && hold_t != '1) hold_t = hold_t + 1'b1;
      if (win_on && win_t != '1) win_t = win_t + 1'b1;
      if (cool_t != '0) cool_t = cool_t - 1'b1;

      case (it.mode)
        MODE_ENABLE:  open_win(time_t'(it.request_duration), it.feedback_request,
                               it.radio_ready);
        MODE_DISABLE: close_win(SHUT_SOFT);
        default: ;
      endcase

      held = sample_button(it.button_level);
      case (phase)
        PH_IDLE: begin
          if (held) begin
            phase = PH_PRESSED;
            hold_t = '0;
          end
        end
        PH_PRESSED: begin
          if (!held) begin
            phase = PH_IDLE;
            cool_t = cool_len;
          end else begin
            if (64'(hold_t) >= 64'(reboot_hold)) reboot_hit = 1'b1;
            if (64'(hold_t) >= 64'(long_hold)) begin
              phase = PH_LONG;
              open_win('0, 1'b1, it.radio_ready);
            end
          end
        end
        PH_LONG: begin
          if (!held) phase = PH_IDLE;
          else if (64'(hold_t) >= 64'(reboot_hold)) reboot_hit = 1'b1;
        end
        default: phase = PH_IDLE;
      endcase

      if (win_on && win_t >= win_len) close_win(SHUT_TIMEOUT);
      if (win_on && win_t < win_len) left = win_len - win_t;

      r.pressed_stable = (cool_t == '0) && (level == 1'b0);
      r.window_open    = win_on;
      r.feedback_on    = win_on && fb_on;
      r.remaining_ms   = CFG_BITS'(left);
      r.start_pulse    = started;
      r.enable_failed  = failed;
      r.shutdown_kind  = shut_kind;
      r.reboot_request = reboot_hit;
      return r;
    endfunction

    function void note_item(item_t it);
      expected_ticks.push_back(predict_tick(it));
    endfunction

    function void flag(string what, longint unsigned e, longint unsigned a);
      errors++;
      if (shown < 40) begin
        shown++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, e, a);
      end
    endfunction

    function void check_field(string what, longint unsigned e, longint unsigned a);
      if (e != a) flag(what, e, a);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_ticks.size() == 0) begin
        flag("unexpected result, remaining_ms", 0, got.remaining_ms);
        return;
      end
      want = expected_ticks.pop_front();
      check_field("pressed_stable", want.pressed_stable, got.pressed_stable);
      check_field("window_open", want.window_open, got.window_open);
      check_field("feedback_on", want.feedback_on, got.feedback_on);
      check_field("remaining_ms", want.remaining_ms, got.remaining_ms);
      check_field("start_pulse", want.start_pulse, got.start_pulse);
      check_field("enable_failed", want.enable_failed, got.enable_failed);
      check_field("shutdown_kind", want.shutdown_kind, got.shutdown_kind);
      check_field("reboot_request", want.reboot_request, got.reboot_request);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, block and channels
  // ---------------------------------------------------------------------------
  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  lpte_item_if   item_ch ();
  lpte_result_if result_ch ();

  long_press_timed_enable_core dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  press_window_scoreboard sb = new();

  int unsigned cycle_count = 0;
  // calm stretches: no gaps on that side while set
  bit          source_calm = 1'b0;
  bit          sink_calm = 1'b0;

  // button stimulus: current level, ticks left in this run, glitchy run or not
  logic        btn_level = 1'b1;
  int unsigned run_left = 0;
  bit          run_noisy = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: ends the run as failed once the cycle limit is reached
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls on ready, every transfer goes to the scoreboard.
  // valid, ready and payload are read right after the edge, so they are the
  // values the block saw at that edge
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    stall = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) sb.check_result(result_ch.payload);
      if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
      if (stall > 0) begin
        stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        stall = pick_gap(sink_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item side
  // ---------------------------------------------------------------------------

  // one item transfer; valid stays high when the next item follows at once,
  // so it is never dropped and raised in the same step
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = pick_gap(source_calm);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.payload <= it;
    do begin
      @(posedge clk);
    end while (!item_ch.ready);
    sb.note_item(it);
  endtask

  task automatic send_fields(logic [1:0] md, logic btn, logic rdy, logic [CFG_BITS-1:0] dur,
                             logic fb);
    item_t it;
    it.mode = md;
    it.button_level = btn;
    it.radio_ready = rdy;
    it.request_duration = dur;
    it.feedback_request = fb;
    send_item(it);
  endtask

  // every expected result back, then a settle wait so the pipeline empties
  task automatic wait_drained();
    while (sb.expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // all five registers, only while the block is idle
  task automatic write_regs(logic [CFG_BITS-1:0] lp, logic [CFG_BITS-1:0] rb,
                            logic [CFG_BITS-1:0] dw, logic [SHORT_BITS-1:0] db,
                            logic [SHORT_BITS-1:0] cd);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_REBOOT_PRESS, rb);
    write_reg(CFG_DEFAULT_WINDOW, dw);
    write_reg(CFG_DEBOUNCE, CFG_BITS'(db));
    write_reg(CFG_COOLDOWN, CFG_BITS'(cd));
    cfg_we <= 1'b0;
  endtask

  // random tick: the button moves in runs of pressed and released time sized
  // against the current thresholds (short taps, long holds, holds past reboot),
  // a quarter of the runs glitch; software commands arrive now and then
  function automatic item_t next_tick_item();
    item_t           it;
    int unsigned     r;
    longint unsigned lo;
    longint unsigned hi;
    if (run_left == 0) begin
      btn_level = !btn_level;
      run_noisy = ($urandom_range(0, 3) == 0);
      if (btn_level == 1'b0) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          lo = 1;
          hi = longint'(sb.long_hold) + 1;
        end else if (r < 8) begin
          lo = longint'(sb.long_hold);
          hi = longint'(sb.reboot_hold) + 6;
        end else begin
          lo = 1;
          hi = 4;
        end
        if (hi > 300) hi = 300;
        if (lo > hi) lo = hi;
        if (lo == 0) lo = 1;
      end else begin
        lo = 1;
        hi = longint'(sb.cool_len) + longint'(sb.quiet_need) + 20;
        if (hi > 300) hi = 300;
      end
      run_left = $urandom_range(int'(lo), int'(hi));
    end
    run_left--;
    it.button_level = btn_level ^ (run_noisy && ($urandom_range(0, 9) == 0));

    r = $urandom_range(0, 99);
    if (r < 84) it.mode = MODE_TICK;
    else if (r < 92) it.mode = MODE_ENABLE;
    else if (r < 98) it.mode = MODE_DISABLE;
    else it.mode = MODE_UNUSED;

    it.radio_ready = ($urandom_range(0, 9) != 0);
    it.feedback_request = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 35) it.request_duration = '0;
    else if (r < 85) it.request_duration = $urandom_range(1, 250);
    else it.request_duration = $urandom;
    return it;
  endfunction

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) source_calm = !source_calm;
      send_item(next_tick_item());
    end
    item_ch.valid <= 1'b0;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.payload <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LONG_PRESS;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, power-on register values: software commands
    send_fields(MODE_TICK, 1'b1, 1'b1, '0, 1'b0);
    send_fields(MODE_ENABLE, 1'b1, 1'b1, '0, 1'b1);            // default length window
    send_fields(MODE_ENABLE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0); // restart while open
    send_fields(MODE_UNUSED, 1'b1, 1'b1, '0, 1'b0);            // unused mode is a tick
    send_fields(MODE_DISABLE, 1'b1, 1'b1, '0, 1'b0);           // soft stop
    send_fields(MODE_DISABLE, 1'b1, 1'b0, '0, 1'b1);           // disable while closed
    send_fields(MODE_ENABLE, 1'b1, 1'b0, 32'h1234, 1'b1);      // radio not ready
    send_fields(MODE_ENABLE, 1'b1, 1'b1, 32'd1, 1'b1);         // one tick window
    send_fields(MODE_TICK, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1);   // times out here
    send_fields(MODE_TICK, 1'b1, 1'b1, '0, 1'b0);
    item_ch.valid <= 1'b0;
    wait_drained();

    // directed, tiny thresholds: long press 2, reboot 3, zero default window,
    // no debounce, cooldown 3
    write_regs(32'd2, 32'd3, 32'd0, 16'd0, 16'd3);
    send_fields(MODE_TICK, 1'b1, 1'b1, '0, 1'b0);
    send_fields(MODE_TICK, 1'b0, 1'b1, '0, 1'b0);              // press starts
    send_fields(MODE_ENABLE, 1'b0, 1'b1, 32'd100, 1'b1);       // window opens
    // soft stop and the long press reopening a zero window: timeout wins
    send_fields(MODE_DISABLE, 1'b0, 1'b1, '0, 1'b0);
    send_fields(MODE_TICK, 1'b0, 1'b1, '0, 1'b0);              // held past reboot
    send_fields(MODE_TICK, 1'b1, 1'b1, '0, 1'b0);              // release after long
    send_fields(MODE_TICK, 1'b0, 1'b1, '0, 1'b0);
    send_fields(MODE_TICK, 1'b1, 1'b1, '0, 1'b0);              // short press, cooldown
    send_fields(MODE_TICK, 1'b0, 1'b1, '0, 1'b0);              // ignored in cooldown
    send_fields(MODE_TICK, 1'b0, 1'b1, '0, 1'b0);
    send_fields(MODE_TICK, 1'b0, 1'b1, '0, 1'b0);              // cooldown over, press
    send_fields(MODE_TICK, 1'b0, 1'b0, '0, 1'b0);
    send_fields(MODE_TICK, 1'b0, 1'b0, '0, 1'b0);              // long press, radio down
    send_fields(MODE_TICK, 1'b0, 1'b0, '0, 1'b0);
    item_ch.valid <= 1'b0;
    wait_drained();

    // random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      logic [CFG_BITS-1:0]   lp;
      logic [CFG_BITS-1:0]   rb;
      logic [CFG_BITS-1:0]   dw;
      logic [SHORT_BITS-1:0] db;
      logic [SHORT_BITS-1:0] cd;
      lp = $urandom_range(0, 40);
      rb = $urandom_range(0, lp + 80);
      dw = $urandom_range(0, 150);
      db = SHORT_BITS'($urandom_range(0, 6));
      cd = SHORT_BITS'($urandom_range(0, 25));
      case (ph)
        1: begin                                  // everything at zero
          lp = '0; rb = '0; dw = '0; db = '0; cd = '0;
        end
        3: begin                                  // everything at its top value
          lp = '1; rb = '1; dw = '1; db = '1; cd = '1;
        end
        4: begin                                  // mixed: one short press freezes it
          rb = '1; dw = '1; db = '0; cd = '1;
        end
        default: ;
      endcase
      write_regs(lp, rb, dw, db, cd);
      run_phase(PHASE_ITEMS);
    end

    if (sb.expected_ticks.size() != 0) begin
      sb.flag("results missing at end, count", 0, sb.expected_ticks.size());
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### long_press_timed_enable_core.f
rtl/lpte_pkg.sv
rtl/lpte_item_if.sv
rtl/lpte_step.sv
rtl/long_press_timed_enable_core.sv
rtl/lpte_checker.sv
bench/long_press_timed_enable_core_test.sv
